/* src/pls_pkg.sv */
package pls_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BADPOS   = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // Hit-vector bits that one scan step examines.
    localparam int SCAN_W = 8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_index;
        logic [4:0] length;
    } t_result;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;     // perform insert, delete or unused kind now
        logic load;     // capture the parallel compare of a search
        logic scan;     // examine the next group of hit bits
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_sts;

    function automatic logic [2:0] prio8(input logic [SCAN_W-1:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

/* src/pls_ctrl.sv */
module pls_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_kind,
    input  pls_pkg::t_sts   i_sts,
    output pls_pkg::t_ctl   o_ctl,
    output logic            o_busy
);

    pls_pkg::t_state r_state;
    pls_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b0;
        case (r_state)
            pls_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_kind == pls_pkg::KIND_SEARCH) begin
                        o_ctl.load = 1'b1;
                        n_state    = pls_pkg::S_SCAN;
                    end else begin
                        o_ctl.exec = 1'b1;
                    end
                end
            end
            pls_pkg::S_SCAN: begin
                o_busy     = 1'b1;
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = pls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pls_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* src/pls_datapath.sv */
module pls_datapath #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pls_pkg::t_ctl    i_ctl,
    input  pls_pkg::t_cmd    i_cmd,
    output pls_pkg::t_sts    o_sts,
    output pls_pkg::t_result o_result,
    output logic             o_done
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int HW = ((DEPTH + pls_pkg::SCAN_W - 1) / pls_pkg::SCAN_W) * pls_pkg::SCAN_W;

    logic signed [31:0] r_cells [DEPTH];
    logic signed [31:0] n_cells [DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [HW-1:0]      r_hits;
    logic [HW-1:0]      n_hits;
    logic [HW-1:0]      load_hits;
    logic [CW-1:0]      r_base;
    logic [CW-1:0]      n_base;
    pls_pkg::t_result   r_result;
    pls_pkg::t_result   n_result;
    logic               r_done;
    logic               n_done;

    logic               ins_ok;
    logic               del_ok;
    logic               pos_le_cnt;
    logic               pos_lt_cnt;
    logic               is_full;
    logic               low_hit;
    logic               rest_zero;
    logic [HW-1:0]      rest;
    logic [31:0]        hit_idx;

    assign pos_le_cnt = 32'(i_cmd.position) <= 32'(r_count);
    assign pos_lt_cnt = 32'(i_cmd.position) <  32'(r_count);
    assign is_full    = 32'(r_count) == 32'(DEPTH);
    assign ins_ok     = i_ctl.exec && (i_cmd.kind == pls_pkg::KIND_INSERT)
                        && pos_le_cnt && !is_full;
    assign del_ok     = i_ctl.exec && (i_cmd.kind == pls_pkg::KIND_DELETE) && pos_lt_cnt;

    // Each cell takes its own value, the new value, or a neighbor's.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic from_low;
        logic from_high;
        logic take_new;
        assign take_new  = ins_ok && (32'(g) == 32'(i_cmd.position));
        assign from_low  = ins_ok && (32'(g) >  32'(i_cmd.position));
        assign from_high = del_ok && (32'(g) >= 32'(i_cmd.position));
        if (g == 0) begin : g_first
            always_comb begin
                if (take_new) begin
                    n_cells[g] = i_cmd.value;
                end else if (from_high) begin
                    n_cells[g] = r_cells[g + 1];
                end else begin
                    n_cells[g] = r_cells[g];
                end
            end
            assign load_hits[g] = (r_cells[g] == i_cmd.value) && (32'(g) < 32'(r_count))
                                  && !from_low;
        end else if (g == DEPTH - 1) begin : g_last
            always_comb begin
                if (take_new) begin
                    n_cells[g] = i_cmd.value;
                end else if (from_low) begin
                    n_cells[g] = r_cells[g - 1];
                end else begin
                    n_cells[g] = r_cells[g];
                end
            end
            assign load_hits[g] = (r_cells[g] == i_cmd.value) && (32'(g) < 32'(r_count))
                                  && !from_high;
        end else begin : g_mid
            always_comb begin
                if (take_new) begin
                    n_cells[g] = i_cmd.value;
                end else if (from_low) begin
                    n_cells[g] = r_cells[g - 1];
                end else if (from_high) begin
                    n_cells[g] = r_cells[g + 1];
                end else begin
                    n_cells[g] = r_cells[g];
                end
            end
            assign load_hits[g] = (r_cells[g] == i_cmd.value) && (32'(g) < 32'(r_count));
        end
    end

    if (HW > DEPTH) begin : g_pad
        assign load_hits[HW-1:DEPTH] = '0;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cells[i] <= n_cells[i];
        end
    end

    assign low_hit   = |r_hits[pls_pkg::SCAN_W-1:0];
    assign rest      = r_hits >> pls_pkg::SCAN_W;
    assign rest_zero = (rest == '0);
    assign hit_idx   = 32'(r_base) + 32'(pls_pkg::prio8(r_hits[pls_pkg::SCAN_W-1:0]));
    assign o_sts.scan_done = low_hit || rest_zero;

    always_comb begin
        n_count  = r_count;
        n_hits   = r_hits;
        n_base   = r_base;
        n_done   = 1'b0;
        n_result = r_result;
        if (i_ctl.exec) begin
            n_done             = 1'b1;
            n_result.status    = pls_pkg::STAT_OK;
            n_result.found_index = '0;
            case (i_cmd.kind)
                pls_pkg::KIND_INSERT: begin
                    if (!pos_le_cnt) begin
                        n_result.status = pls_pkg::STAT_BADPOS;
                    end else if (is_full) begin
                        n_result.status = pls_pkg::STAT_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                pls_pkg::KIND_DELETE: begin
                    if (!pos_lt_cnt) begin
                        n_result.status = pls_pkg::STAT_BADPOS;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
            n_result.length = 5'(32'(n_count));
        end else if (i_ctl.load) begin
            n_hits = load_hits;
            n_base = '0;
        end else if (i_ctl.scan) begin
            if (low_hit) begin
                n_done               = 1'b1;
                n_result.status      = pls_pkg::STAT_OK;
                n_result.found_index = hit_idx[3:0];
                n_result.length      = 5'(32'(r_count));
            end else if (rest_zero) begin
                n_done               = 1'b1;
                n_result.status      = pls_pkg::STAT_NOTFOUND;
                n_result.found_index = '0;
                n_result.length      = 5'(32'(r_count));
            end else begin
                n_hits = rest;
                n_base = r_base + CW'(pls_pkg::SCAN_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_hits   <= n_hits;
        r_base   <= n_base;
        r_result <= n_result;
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

/* src/positional_list_store.sv */
// Ordered list of up to DEPTH signed 32-bit values. A command beat is taken
// at a rising edge where start is high and busy is low; it inserts, deletes or
// searches as given by its kind. Insert and delete (and the unused kind) are
// done in the cycle the beat is taken, with the whole row of cells shifting at
// once, so busy stays low and a new beat can follow in the very next cycle.
// A search captures a parallel compare of all cells, then walks the hit
// vector eight entries per cycle with a small priority encoder; busy is high
// during that walk, which ends at the first group that holds a match, or when
// no hits are left beyond the current group. Every beat gives exactly one
// result beat, shown on o_result for a single cycle with o_done high, in the
// cycle after the last cycle of work. There is no back pressure on the result
// side: the receiver must take each result beat in the cycle it appears.
// Status codes: 0 ok, 1 bad position, 2 not found, 3 list full. The length
// field and the found index carry the low bits of their values when DEPTH is
// large.
module positional_list_store #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pls_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output pls_pkg::t_result o_result
);

    // Command and status between the sequencer and the cell row.
    pls_pkg::t_ctl ctl;
    pls_pkg::t_sts sts;

    pls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_cmd.kind),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // The datapath holds the shift cells, the length counter, the hit
    // vector of a running search and the registered result beat.
    pls_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cmd    (i_cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

/* src/pls_checker.sv */
module pls_checker #(
    parameter int DEPTH = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input pls_pkg::t_cmd    i_cmd,
    input logic             o_done,
    input pls_pkg::t_result o_result
);

    // Non-search beats finish in the cycle they are taken.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind != pls_pkg::KIND_SEARCH) |=> o_done)
        else $error("insert or delete result missing in next cycle");

    // While a search walks its hits, no result can be pending.
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result beat while busy");

    // A full report always comes with the full length.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == pls_pkg::STAT_FULL) |-> o_result.length == 5'(DEPTH))
        else $error("full status with wrong length");

    // Only a successful search carries a nonzero index.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != pls_pkg::STAT_OK) |-> o_result.found_index == '0)
        else $error("nonzero index on failed beat");

endmodule

bind positional_list_store pls_checker #(
    .DEPTH (DEPTH)
) u_pls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

/* tb/testbench.sv */
module testbench;

    // The block has no name for the fourth kind code, so it gets one here.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1850;
    // This limit leaves a wide margin on top of the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    // The wait after the last expected result, before the summary is printed.
    localparam int DRAIN_CYCLES = 8;
    // No gaps are inserted during this window of random beats.
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1100;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    pls_pkg::t_cmd    i_cmd   = '0;
    logic             o_done;
    pls_pkg::t_result o_result;

    always #6 i_clk = ~i_clk;

    positional_list_store #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // This is the testbench's own copy of the list. Only entries below list_len are ever read.
    logic signed [31:0] list_vals [LIST_DEPTH];
    int unsigned        list_len = 0;

    // These are the results of accepted command beats that have not come back yet, oldest first.
    pls_pkg::t_result pending_results[$];

    int errors      = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_hits      = 0;
    int n_notfound  = 0;
    int n_badpos    = 0;
    int n_full      = 0;
    int n_max_len   = 0;
    int cycle_count = 0;

    typedef struct {
        pls_pkg::t_cmd    cmd;
        bit               typed;
        pls_pkg::t_result want;
    } t_dir_row;

    t_dir_row dir_tab[$];

    // Apply one command to the list copy and return the result beat that the block must produce.
    function automatic pls_pkg::t_result apply_list_op(input pls_pkg::t_cmd c);
        pls_pkg::t_result r;
        int               i;
        int               hit;
        r = '0;
        r.status = pls_pkg::STAT_OK;
        case (c.kind)
            pls_pkg::KIND_INSERT: begin
                // A bad position is checked before a full list.
                if (c.position > list_len) begin
                    r.status = pls_pkg::STAT_BADPOS;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = pls_pkg::STAT_FULL;
                end else begin
                    for (i = list_len; i > c.position; i--) begin
                        list_vals[i] = list_vals[i-1];
                    end
                    list_vals[c.position] = c.value;
                    list_len++;
                end
            end
            pls_pkg::KIND_SEARCH: begin
                hit = -1;
                for (i = 0; i < list_len; i++) begin
                    if (hit < 0 && list_vals[i] == c.value) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = pls_pkg::STAT_NOTFOUND;
                end else begin
                    r.found_index = 4'(hit);
                end
            end
            pls_pkg::KIND_DELETE: begin
                if (c.position >= list_len) begin
                    r.status = pls_pkg::STAT_BADPOS;
                end else begin
                    for (i = c.position; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i+1];
                    end
                    list_len--;
                end
            end
            default: begin
                // The unused kind only reports the current length.
            end
        endcase
        r.length = 5'(list_len);
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] kind, input logic [4:0] pos,
                                        input logic signed [31:0] val, input bit typed,
                                        input logic [1:0] st, input logic [3:0] idx,
                                        input logic [4:0] len);
        t_dir_row row;
        row.cmd.kind          = kind;
        row.cmd.position      = pos;
        row.cmd.value         = val;
        row.typed             = typed;
        row.want.status       = st;
        row.want.found_index  = idx;
        row.want.length       = len;
        return row;
    endfunction

    // Values are drawn mostly from a small pool, so that searches hit and duplicates are common.
    // The extremes and fully random words are mixed in.
    function automatic logic signed [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return ($urandom_range(1) != 0) ? 32'sd0 : -32'sd1;
            3, 4, 5, 6: return 32'($urandom_range(7)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    // Make one random command beat. Most beats are well formed: the positions are legal
    // for the current length, and searches often look for a value that is stored.
    // When grow is set, the mix leans toward inserts, so the list reaches full.
    // Otherwise it leans toward deletes, so the list drains back to empty.
    function automatic pls_pkg::t_cmd make_random_cmd(input bit grow);
        pls_pkg::t_cmd c;
        int unsigned   roll;
        roll       = $urandom_range(99);
        c.position = 5'($urandom_range(31));
        c.value    = pick_value();
        if (roll < 3) begin
            c.kind = KIND_UNUSED;
        end else if (roll < 9) begin
            // These are noise beats: any position is allowed, so most of them are rejected.
            c.kind = ($urandom_range(1) != 0) ? pls_pkg::KIND_INSERT : pls_pkg::KIND_DELETE;
        end else if (roll < (grow ? 60 : 30)) begin
            c.kind     = pls_pkg::KIND_INSERT;
            c.position = 5'($urandom_range(list_len));
        end else if (roll < (grow ? 80 : 55)) begin
            c.kind = pls_pkg::KIND_SEARCH;
            if (list_len > 0 && $urandom_range(99) < 65) begin
                c.value = list_vals[$urandom_range(list_len - 1)];
            end
        end else begin
            c.kind = pls_pkg::KIND_DELETE;
            if (list_len > 0) begin
                c.position = 5'($urandom_range(list_len - 1));
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result beat %0d: %s is %0d, expected %0d",
                 n_results, what, got, want);
        errors++;
    endtask

    // Present one command beat and hold it until the block takes it.
    // start is not lowered here. If the next beat follows at once, the caller raises start
    // again and changes the command in this same step, and start gets only one assignment.
    task automatic send_cmd(input pls_pkg::t_cmd c, input bit typed,
                            input pls_pkg::t_result want);
        pls_pkg::t_result pred;
        start <= 1'b1;
        i_cmd <= c;
        do begin
            @(posedge i_clk);
        end while (busy);
        pred = apply_list_op(c);
        pending_results.push_back(typed ? want : pred);
        n_accepted++;
        if (c.kind == pls_pkg::KIND_SEARCH && pred.status == pls_pkg::STAT_OK) n_hits++;
        if (pred.status == pls_pkg::STAT_NOTFOUND) n_notfound++;
        if (pred.status == pls_pkg::STAT_BADPOS) n_badpos++;
        if (pred.status == pls_pkg::STAT_FULL) n_full++;
        if (list_len == LIST_DEPTH) n_max_len++;
    endtask

    // Lower start for an idle gap set by n. The command bus carries junk during that
    // gap, which the block must ignore.
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        i_cmd <= pls_pkg::t_cmd'(39'({$urandom, $urandom}));
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(99) < 10) begin
            idle_cycles($urandom_range(1, 5));
        end
    endtask

    // The result side cannot stall. Each strobe is taken in the cycle it appears,
    // and it is checked against the oldest waiting expectation.
    always @(posedge i_clk) begin : result_check
        pls_pkg::t_result want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending, status", o_result.status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.found_index !== want.found_index)
                    report_mismatch("found_index", o_result.found_index, want.found_index);
                if (o_result.length !== want.length)
                    report_mismatch("length", o_result.length, want.length);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        bit grow;
        int k;

        // This directed table comes first. Rows whose result is obvious carry it typed in.
        // The rest are checked against the list copy.
        dir_tab.push_back(mk_row(pls_pkg::KIND_SEARCH, 5'd0, 32'sd0, 1,
                                 pls_pkg::STAT_NOTFOUND, 4'd0, 5'd0));
        dir_tab.push_back(mk_row(pls_pkg::KIND_DELETE, 5'd0, 32'sd0, 1,
                                 pls_pkg::STAT_BADPOS, 4'd0, 5'd0));
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd1, 32'sd5, 1,
                                 pls_pkg::STAT_BADPOS, 4'd0, 5'd0));
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd0, 32'sh8000_0000, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd1));
        // An insert at the current length appends.
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd1, 32'sh7fff_ffff, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd2));
        // An insert at the head must move every entry up by one.
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd0, -32'sd1, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd3));
        dir_tab.push_back(mk_row(pls_pkg::KIND_SEARCH, 5'd31, 32'sh8000_0000, 1,
                                 pls_pkg::STAT_OK, 4'd1, 5'd3));
        dir_tab.push_back(mk_row(KIND_UNUSED, 5'd31, -32'sd1, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd3));
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd31, 32'sd9, 1,
                                 pls_pkg::STAT_BADPOS, 4'd0, 5'd3));
        // A delete at the length is one past the end.
        dir_tab.push_back(mk_row(pls_pkg::KIND_DELETE, 5'd3, 32'sd0, 1,
                                 pls_pkg::STAT_BADPOS, 4'd0, 5'd3));
        dir_tab.push_back(mk_row(pls_pkg::KIND_DELETE, 5'd1, 32'sd0, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd2));
        dir_tab.push_back(mk_row(pls_pkg::KIND_SEARCH, 5'd0, 32'sh8000_0000, 1,
                                 pls_pkg::STAT_NOTFOUND, 4'd0, 5'd2));
        // Fill the list through the head, so that the last cell holds the largest value.
        for (k = 0; k < LIST_DEPTH - 2; k++) begin
            dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd0, 32'sd100 + k, 0,
                                     pls_pkg::STAT_OK, 4'd0, 5'd0));
        end
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd16, 32'sd1, 1,
                                 pls_pkg::STAT_FULL, 4'd0, 5'd16));
        // On a full list a bad position still wins over full.
        dir_tab.push_back(mk_row(pls_pkg::KIND_INSERT, 5'd17, 32'sd1, 1,
                                 pls_pkg::STAT_BADPOS, 4'd0, 5'd16));
        dir_tab.push_back(mk_row(pls_pkg::KIND_SEARCH, 5'd0, 32'sh7fff_ffff, 1,
                                 pls_pkg::STAT_OK, 4'd15, 5'd16));
        dir_tab.push_back(mk_row(pls_pkg::KIND_DELETE, 5'd15, 32'sd0, 1,
                                 pls_pkg::STAT_OK, 4'd0, 5'd15));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            send_cmd(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);
            maybe_idle(1'b1);
        end

        // The random part follows. The insert and delete mix flips near the ends,
        // so the list swings between empty and full many times.
        grow = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (list_len == LIST_DEPTH && $urandom_range(99) < 20) grow = 1'b0;
            if (list_len == 0 && $urandom_range(99) < 20) grow = 1'b1;
            if ($urandom_range(99) == 0) grow = !grow;
            send_cmd(make_random_cmd(grow), 1'b0, '0);
            maybe_idle(k < QUIET_FIRST || k > QUIET_LAST);
        end
        idle_cycles(1);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command beats, %0d result beats, %0d cycles, %0d mismatches",
                 n_accepted, n_results, cycle_count, errors);
        $display("search hits %0d, not found %0d, bad position %0d, list full %0d, at depth %0d",
                 n_hits, n_notfound, n_badpos, n_full, n_max_len);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
